/* sv/cpt_pkg.sv */
// shared types, constants and the turn-sign fold for the convex polygon checker
`default_nettype none

package cpt_pkg;

   // field widths fixed by the stream format
   localparam int FIELD_BITS    = 16;
   localparam int REQ_DATA_BITS = 2 * FIELD_BITS;
   localparam int RSP_DATA_BITS = 8;
   localparam int RSP_USER_BITS = 1;

   // number of turns checked per item: the regular turn and two wrap-around turns
   localparam int TURNS = 3;

   // sign of one turn
   typedef enum logic [1:0] {
      TURN_NONE,
      TURN_POS,
      TURN_NEG
   } turn_type;

   // running sign state across a polygon
   typedef struct packed {
      turn_type sign;
      logic     failed;
   } fold_type;

   // fold one turn into the running state; zero turns leave it alone
   function automatic fold_type fold_turn(fold_type st, turn_type s);
      fold_type r;
      r = st;
      if (s != TURN_NONE) begin
         if (st.sign != TURN_NONE && st.sign != s) begin
            r.failed = 1'b1;
         end
         r.sign = s;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/convex_polygon_turn_check.sv */
// Convex polygon checker: takes vertices as a stream, returns one verdict per polygon.
//
// Input channel (req_): one vertex per item, x in req_tdata[15:0], y in
// req_tdata[31:16]; req_tlast marks the last vertex of a polygon. Coordinates
// use the low COORD_BITS bits, sign-extended.
// Result channel (rsp_): one item per polygon, sent for its last vertex only.
// rsp_tdata[0] is is_convex, rsp_tuser[0] is too_few (fewer than three vertices,
// is_convex then reads 0). Zero turns are ignored; self-intersection is not seen.
// Throughput: one vertex per cycle while the block is not stalled. The result item
// shows on rsp_tvalid after the last vertex passes the difference and product registers,
// then the sign fold into the result register.
// While a result waits in the output register the block keeps accepting vertices;
// it stops taking items only when the next result reaches the fold stage before the
// waiting one has been taken.
// Reset (synchronous, active high) empties the pipeline, drops any pending result
// and starts a new polygon.
`default_nettype none

module convex_polygon_turn_check #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // vx [15:0], vy [31:16]
   input  wire logic [cpt_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  wire logic                                req_tlast,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // is_convex [0], zero padding [7:1]
   output      logic [cpt_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // too_few [0]
   output      logic [cpt_pkg::RSP_USER_BITS-1:0]   rsp_tuser,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready
);
   import cpt_pkg::*;

   localparam int CW       = COORD_BITS;
   localparam int DW       = CW + 1;
   localparam int PW       = 2 * DW;
   localparam int RAW_BITS = (CW > FIELD_BITS) ? CW : FIELD_BITS;

   // pipeline enable and input handshake
   logic en;
   logic req_fire;

   // vertex history
   logic signed [CW-1:0] first_x_ff, first_y_ff, second_x_ff, second_y_ff;
   logic signed [CW-1:0] older_x_ff, older_y_ff, recent_x_ff, recent_y_ff;
   logic [1:0]           seen_ff;

   // incoming coordinates
   logic [RAW_BITS-1:0]  raw_x, raw_y;
   logic signed [CW-1:0] cur_x, cur_y;

   // corner points of the three turns
   logic signed [CW-1:0] ax [TURNS];
   logic signed [CW-1:0] ay [TURNS];
   logic signed [CW-1:0] bx [TURNS];
   logic signed [CW-1:0] by [TURNS];
   logic signed [CW-1:0] cx [TURNS];
   logic signed [CW-1:0] cy [TURNS];

   // difference stage
   logic                 s1_valid_ff, s1_last_ff, s1_few_ff;
   logic [TURNS-1:0]     s1_use_ff;
   logic signed [DW-1:0] s1_e1x_ff [TURNS];
   logic signed [DW-1:0] s1_e1y_ff [TURNS];
   logic signed [DW-1:0] s1_e2x_ff [TURNS];
   logic signed [DW-1:0] s1_e2y_ff [TURNS];

   // product stage
   logic                 s2_valid_ff, s2_last_ff, s2_few_ff;
   logic [TURNS-1:0]     s2_use_ff;
   logic signed [PW-1:0] s2_p_ff [TURNS];
   logic signed [PW-1:0] s2_q_ff [TURNS];

   // sign fold
   fold_type             fold_ff;
   fold_type             fold_in;
   turn_type             turn_s [TURNS];

   // result register
   logic                 rsp_valid_ff;
   logic                 is_convex_ff, too_few_ff;

   // stall only when a new result would land on one not yet taken
   assign en         = !(rsp_valid_ff && !rsp_tready && s2_valid_ff && s2_last_ff);
   assign req_tready = en;
   assign req_fire   = req_tvalid && en;

   // take the low coordinate bits of each field
   assign raw_x = RAW_BITS'(req_tdata[FIELD_BITS-1:0]);
   assign raw_y = RAW_BITS'(req_tdata[REQ_DATA_BITS-1:FIELD_BITS]);
   assign cur_x = raw_x[CW-1:0];
   assign cur_y = raw_y[CW-1:0];

   // regular turn older -> recent -> new, then the two wrap-around turns
   always_comb begin
      ax[0] = older_x_ff;  ay[0] = older_y_ff;
      bx[0] = recent_x_ff; by[0] = recent_y_ff;
      cx[0] = cur_x;       cy[0] = cur_y;
      ax[1] = recent_x_ff; ay[1] = recent_y_ff;
      bx[1] = cur_x;       by[1] = cur_y;
      cx[1] = first_x_ff;  cy[1] = first_y_ff;
      ax[2] = cur_x;       ay[2] = cur_y;
      bx[2] = first_x_ff;  by[2] = first_y_ff;
      cx[2] = second_x_ff; cy[2] = second_y_ff;
   end

   // vertex history, cleared at the end of each polygon
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 2'd0;
      end else if (req_fire) begin
         if (req_tlast) begin
            seen_ff <= 2'd0;
         end else if (seen_ff != 2'd3) begin
            seen_ff <= seen_ff + 2'd1;
         end
      end
      if (req_fire) begin
         if (seen_ff == 2'd0) begin
            first_x_ff <= cur_x;
            first_y_ff <= cur_y;
         end
         if (seen_ff == 2'd1) begin
            second_x_ff <= cur_x;
            second_y_ff <= cur_y;
         end
         older_x_ff  <= recent_x_ff;
         older_y_ff  <= recent_y_ff;
         recent_x_ff <= cur_x;
         recent_y_ff <= cur_y;
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // edge differences
   always_ff @(posedge clock) begin
      if (en) begin
         s1_last_ff   <= req_tlast;
         s1_few_ff    <= req_tlast && (seen_ff < 2'd2);
         s1_use_ff[0] <= (seen_ff >= 2'd2);
         s1_use_ff[1] <= req_tlast && (seen_ff >= 2'd2);
         s1_use_ff[2] <= req_tlast && (seen_ff >= 2'd2);
         for (int i = 0; i < TURNS; i++) begin
            s1_e1x_ff[i] <= {bx[i][CW-1], bx[i]} - {ax[i][CW-1], ax[i]};
            s1_e1y_ff[i] <= {by[i][CW-1], by[i]} - {ay[i][CW-1], ay[i]};
            s1_e2x_ff[i] <= {cx[i][CW-1], cx[i]} - {bx[i][CW-1], bx[i]};
            s1_e2y_ff[i] <= {cy[i][CW-1], cy[i]} - {by[i][CW-1], by[i]};
         end
      end
   end

   // partial products of each cross product
   always_ff @(posedge clock) begin
      if (en) begin
         s2_last_ff <= s1_last_ff;
         s2_few_ff  <= s1_few_ff;
         s2_use_ff  <= s1_use_ff;
         for (int i = 0; i < TURNS; i++) begin
            s2_p_ff[i] <= PW'(s1_e1x_ff[i]) * PW'(s1_e2y_ff[i]);
            s2_q_ff[i] <= PW'(s1_e2x_ff[i]) * PW'(s1_e1y_ff[i]);
         end
      end
   end

   // turn signs folded in polygon order
   always_comb begin
      fold_in = fold_ff;
      for (int i = 0; i < TURNS; i++) begin
         if (!s2_use_ff[i]) begin
            turn_s[i] = TURN_NONE;
         end else if (s2_p_ff[i] > s2_q_ff[i]) begin
            turn_s[i] = TURN_POS;
         end else if (s2_p_ff[i] < s2_q_ff[i]) begin
            turn_s[i] = TURN_NEG;
         end else begin
            turn_s[i] = TURN_NONE;
         end
         fold_in = fold_turn(fold_in, turn_s[i]);
      end
   end

   // sign state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff      <= '{sign: TURN_NONE, failed: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !(en && s2_valid_ff && s2_last_ff)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (en && s2_valid_ff) begin
            if (s2_last_ff) begin
               fold_ff      <= '{sign: TURN_NONE, failed: 1'b0};
               rsp_valid_ff <= 1'b1;
               is_convex_ff <= !s2_few_ff && !fold_in.failed;
               too_few_ff   <= s2_few_ff;
            end else begin
               fold_ff <= fold_in;
            end
         end
      end
   end

   // result ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(is_convex_ff);
   assign rsp_tuser  = RSP_USER_BITS'(too_few_ff);

   // a short polygon never reads as convex
   a_few_not_convex: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tdata[0])
      else $error("too_few result with is_convex set");

   // a failure always follows a recorded nonzero turn
   a_failed_has_sign: assert property (@(posedge clock) disable iff (reset)
      fold_ff.failed |-> fold_ff.sign != TURN_NONE)
      else $error("failed set with no turn sign");

   // the last vertex starts a new polygon
   a_last_clears_count: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> seen_ff == 2'd0)
      else $error("vertex count not cleared after last vertex");

   // a last vertex leaving the fold stage always gives a result
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      en && s2_valid_ff && s2_last_ff |=> rsp_tvalid && fold_ff.sign == TURN_NONE)
      else $error("last vertex did not produce a result");

endmodule

`default_nettype wire

/* dv/convex_polygon_turn_check_test.sv */
// self-checking testbench for the convex polygon checker: stream driver, predictor and monitor
`default_nettype none

module convex_polygon_turn_check_test;

   import cpt_pkg::*;

   localparam int COORD_BITS   = 16;
   localparam int RANDOM_ITEMS = 1850;
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;

   // one vertex as offered on the input stream
   typedef struct packed {
      logic [FIELD_BITS-1:0] vx;
      logic [FIELD_BITS-1:0] vy;
      logic                  last;
   } vertex_item;

   // verdict for one polygon
   typedef struct packed {
      logic is_convex;
      logic too_few;
   } verdict_item;

   logic                     clock;
   logic                     reset;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     req_tlast;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [RSP_USER_BITS-1:0] rsp_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;

   vertex_item  pending_vertices[$];
   verdict_item polygon_verdicts[$];

   int total_items;
   int accepted_items;
   int fail_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;
   int stall_cycles;
   bit hold_request;
   bit hold_taken;

   // running polygon state of the predictor
   logic signed [COORD_BITS-1:0] poly_first_x, poly_first_y;
   logic signed [COORD_BITS-1:0] poly_second_x, poly_second_y;
   logic signed [COORD_BITS-1:0] poly_older_x, poly_older_y;
   logic signed [COORD_BITS-1:0] poly_recent_x, poly_recent_y;
   logic [1:0]                   poly_seen;
   turn_type                     poly_sign;
   logic                         poly_bent;

   convex_polygon_turn_check #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // low COORD_BITS bits of a field, sign-extended
   function automatic longint coord_value(logic [FIELD_BITS-1:0] raw);
      longint span;
      longint v;
      span = longint'(1) << COORD_BITS;
      v = longint'(raw) & (span - 1);
      if (v >= (span >> 1)) begin
         v = v - span;
      end
      return v;
   endfunction

   // direction of the turn a -> b -> c
   function automatic turn_type turn_direction(longint ax, longint ay, longint bx,
                                               longint by, longint cx, longint cy);
      longint lhs;
      longint rhs;
      lhs = (bx - ax) * (cy - by);
      rhs = (cx - bx) * (by - ay);
      if (lhs > rhs) begin
         return TURN_POS;
      end
      if (lhs < rhs) begin
         return TURN_NEG;
      end
      return TURN_NONE;
   endfunction

   // fold one turn into the running sign; straight turns are skipped
   task automatic record_turn(turn_type s);
      if (s != TURN_NONE) begin
         if (poly_sign != TURN_NONE && poly_sign != s) begin
            poly_bent = 1'b1;
         end
         poly_sign = s;
      end
   endtask

   task automatic clear_polygon();
      poly_first_x  = '0;
      poly_first_y  = '0;
      poly_second_x = '0;
      poly_second_y = '0;
      poly_older_x  = '0;
      poly_older_y  = '0;
      poly_recent_x = '0;
      poly_recent_y = '0;
      poly_seen     = 2'd0;
      poly_sign     = TURN_NONE;
      poly_bent     = 1'b0;
   endtask

   // advance the polygon state by one accepted vertex, queue its verdict on the last one
   task automatic predict_vertex(logic [FIELD_BITS-1:0] raw_x, logic [FIELD_BITS-1:0] raw_y,
                                 logic last);
      longint x;
      longint y;
      x = coord_value(raw_x);
      y = coord_value(raw_y);
      case (poly_seen)
         2'd0: begin
            poly_first_x = x[COORD_BITS-1:0];
            poly_first_y = y[COORD_BITS-1:0];
         end
         2'd1: begin
            poly_second_x = x[COORD_BITS-1:0];
            poly_second_y = y[COORD_BITS-1:0];
         end
         default: begin
            record_turn(turn_direction(poly_older_x, poly_older_y,
                                       poly_recent_x, poly_recent_y, x, y));
         end
      endcase
      poly_older_x  = poly_recent_x;
      poly_older_y  = poly_recent_y;
      poly_recent_x = x[COORD_BITS-1:0];
      poly_recent_y = y[COORD_BITS-1:0];
      if (poly_seen != 2'd3) begin
         poly_seen = poly_seen + 2'd1;
      end
      if (last) begin
         if (poly_seen != 2'd3) begin
            polygon_verdicts.push_back('{is_convex: 1'b0, too_few: 1'b1});
         end else begin
            // closing turns back onto the first two vertices
            record_turn(turn_direction(poly_older_x, poly_older_y, poly_recent_x,
                                       poly_recent_y, poly_first_x, poly_first_y));
            record_turn(turn_direction(poly_recent_x, poly_recent_y, poly_first_x,
                                       poly_first_y, poly_second_x, poly_second_y));
            polygon_verdicts.push_back('{is_convex: ~poly_bent, too_few: 1'b0});
         end
         clear_polygon();
      end
   endtask

   task automatic add_vertex(int x, int y, bit last);
      pending_vertices.push_back('{vx: x[FIELD_BITS-1:0], vy: y[FIELD_BITS-1:0], last: last});
      total_items++;
   endtask

   task automatic add_polygon(int xs[$], int ys[$]);
      for (int i = 0; i < xs.size(); i++) begin
         add_vertex(xs[i], ys[i], i == xs.size() - 1);
      end
   endtask

   // one random polygon: convex shapes most often, some dented, scattered, short or collinear
   task automatic add_random_polygon();
      int  xs[$];
      int  ys[$];
      int  kind;
      int  n;
      int  cx;
      int  cy;
      int  dir;
      int  pick;
      int  dx;
      int  dy;
      real rad;
      real ang;
      real step;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         n    = $urandom_range(3, 10);
         cx   = $urandom_range(0, 32000) - 16000;
         cy   = $urandom_range(0, 32000) - 16000;
         rad  = 2.0 + $urandom_range(0, 15990);
         ang  = $urandom_range(0, 6283) / 1000.0;
         step = 6.2831853 / n;
         dir  = $urandom_range(0, 1) ? 1 : -1;
         for (int i = 0; i < n; i++) begin
            xs.push_back(cx + $rtoi(rad * $cos(ang)));
            ys.push_back(cy + dir * $rtoi(rad * $sin(ang)));
            ang = ang + step * (0.6 + 0.35 * ($urandom_range(0, 1000) / 1000.0));
         end
         // pull one vertex toward the center to break convexity
         if (kind >= 40) begin
            pick = $urandom_range(0, n - 1);
            xs[pick] = (xs[pick] + cx) / 2;
            ys[pick] = (ys[pick] + cy) / 2;
         end
      end else if (kind < 80) begin
         n = (kind < 70) ? $urandom_range(3, 8) : $urandom_range(1, 2);
         for (int i = 0; i < n; i++) begin
            xs.push_back($urandom_range(0, 65535) - 32768);
            ys.push_back($urandom_range(0, 65535) - 32768);
         end
      end else begin
         n  = $urandom_range(3, 7);
         cx = $urandom_range(0, 60000) - 30000;
         cy = $urandom_range(0, 60000) - 30000;
         dx = $urandom_range(0, 100) - 50;
         dy = $urandom_range(0, 100) - 50;
         for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 10);
            xs.push_back(cx + pick * dx);
            ys.push_back(cy + pick * dy);
         end
      end
      add_polygon(xs, ys);
   endtask

   // input side: offer the next pending vertex, predict on acceptance
   always @(posedge clock) begin : drive_vertices
      vertex_item nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_vertex(req_tdata[FIELD_BITS-1:0], req_tdata[2*FIELD_BITS-1:FIELD_BITS],
                           req_tlast);
            accepted_items++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_vertices.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = pending_vertices.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {nxt.vy, nxt.vx};
               req_tlast  <= nxt.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result side ready: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_taken <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // result check against the oldest predicted verdict
   always @(posedge clock) begin : check_verdicts
      verdict_item want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (polygon_verdicts.size() == 0) begin
            $display("%0t: unexpected result item tdata=%h tuser=%h",
                     $time, rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = polygon_verdicts.pop_front();
            if (rsp_tdata !== {{(RSP_DATA_BITS-1){1'b0}}, want.is_convex}) begin
               $display("%0t: is_convex mismatch, expected tdata=%h actual tdata=%h",
                        $time, {{(RSP_DATA_BITS-1){1'b0}}, want.is_convex}, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser[0] !== want.too_few) begin
               $display("%0t: too_few mismatch, expected %b actual %b",
                        $time, want.too_few, rsp_tuser[0]);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // stimulus, phases and end of run
   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      total_items    = 0;
      accepted_items = 0;
      fail_count     = 0;
      stall_cycles   = 0;
      hold_left      = 0;
      hold_taken     = 1'b0;
      hold_request   = 1'b0;
      send_idle_pct  = 18;
      recv_idle_pct  = 55;
      clear_polygon();

      // too few vertices: one and two
      add_polygon('{7}, '{-9});
      add_polygon('{-32768, 32767}, '{32767, -32768});
      // counterclockwise triangle at the coordinate extremes
      add_polygon('{-32768, 32767, 32767}, '{-32768, -32768, 32767});
      // clockwise square at the extremes
      add_polygon('{-32768, 32767, 32767, -32768}, '{32767, 32767, -32768, -32768});
      // collinear points only: every turn straight
      add_polygon('{0, 1, 2}, '{0, 1, 2});
      // dart with one reflex corner
      add_polygon('{0, 4, 1, 0}, '{0, 0, 1, 4});
      // all vertices on one spot
      add_polygon('{5, 5, 5, 5}, '{5, 5, 5, 5});

      while (total_items < RANDOM_ITEMS + 21) begin
         add_random_polygon();
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (accepted_items < total_items / 3) @(posedge clock);
      send_idle_pct <= 55;
      recv_idle_pct <= 18;
      while (accepted_items < (2 * total_items) / 3) @(posedge clock);
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      hold_request  <= 1'b1;

      while (accepted_items < total_items) @(posedge clock);
      while (polygon_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
sv/cpt_pkg.sv
sv/convex_polygon_turn_check.sv
dv/convex_polygon_turn_check_test.sv
